### rtl/qpst_pkg.sv
// Shared types, widths and constants of the quadrature position and speed tracker.
package qpst_pkg;

  localparam int HISTORY_DEPTH_DEF = 100;

  localparam int CNT_W   = 17;
  localparam int MOD_W   = 16;
  localparam int SPD_W   = 20;
  localparam int STAMP_W = 32;
  localparam int DIR_W   = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 20;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [MOD_W-1:0]   COUNT_MODULUS_RST   = 16'd1200;
  localparam logic [SPD_W-1:0]   SPEED_NUMERATOR_RST = 20'd73526;
  localparam logic [STAMP_W-1:0] STAMP_RST           = 32'd1;

  localparam logic [CFG_ADDR_W-1:0] CFG_COUNT_MODULUS   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_NUMERATOR = 1'b1;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_ACW  = 2'd2
  } qpst_dir_t;

  typedef struct packed {
    qpst_dir_t            dir;
    logic [STAMP_W-1:0]   interval;
  } qpst_evt_t;

  typedef struct packed {
    logic [MOD_W-1:0] count_modulus;
    logic [SPD_W-1:0] speed_numerator;
  } qpst_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qpst_qstat_t;

  typedef struct packed {
    logic idle;
    logic avg;
  } qpst_bstat_t;

endpackage

### rtl/quadrature_position_speed_tracker_core.sv
// Top level of the quadrature position and speed tracker.
//
// Input channel in_*: one transaction per encoder edge event carrying the A and
// B levels and a 32-bit microsecond stamp. Output channel out_*: one transaction
// per event with the signed position count, the step direction and the mean of
// the speed history ring. cfg_*: write-only registers, index 0 count modulus,
// index 1 speed numerator, to be written by the user only while the block is
// idle, which the block does not enforce. Events enter a two-deep queue and
// the update engine takes them one at a time, running the speed divide (one bit
// a cycle over 20 bits) beside the position remainder, then forming the average
// by a reciprocal multiply. Each event is popped, divided, added to the history
// and averaged before out_tvalid; up to two further events are taken meanwhile,
// but none is popped until the last result is in the output register. Reset
// clears position, levels, history (through per-slot valid bits) and sets the
// previous stamp to 1; the block accepts events as soon as reset is released.
// When out_tready is low the result holds in the output register and the engine
// waits with its next result, while the queue keeps accepting events until full.
module quadrature_position_speed_tracker_core
  import qpst_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // level_a, level_b, stamp_us[31:0], zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // position_count, step_direction, average_speed, pad
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  qpst_cfg_t   cfg_r, cfg_nxt;
  qpst_qstat_t q_stat;
  qpst_bstat_t b_stat;
  logic        q_push, q_pop;
  qpst_evt_t   q_wdata, q_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_COUNT_MODULUS:   cfg_nxt.count_modulus   = cfg_wdata[MOD_W-1:0];
        CFG_SPEED_NUMERATOR: cfg_nxt.speed_numerator = cfg_wdata[SPD_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count_modulus   <= COUNT_MODULUS_RST;
      cfg_r.speed_numerator <= SPEED_NUMERATOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  qpst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  qpst_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  qpst_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .q_data     (q_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .stat       (b_stat)
  );

  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !q_stat.empty)
    else $error("accepted transaction missing from queue");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(b_stat.avg))
    else $error("result raised outside the averaging step");

  a_idle_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (b_stat.idle && !q_stat.empty))
    else $error("queue popped while engine busy or queue empty");

endmodule

### rtl/qpst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qpst_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 100
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/qpst_div.sv
// Restoring divider, one quotient bit per cycle.
module qpst_div #(
  parameter int NW = 16,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial    = {rem_r, quo_r[NW-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt  = {quo_r[NW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

### rtl/qpst_front.sv
// Input stage: takes edge events, decodes direction and measures the interval.
module qpst_front
  import qpst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // level_a, level_b, stamp_us[31:0], zero pad
  input  qpst_qstat_t           q_stat,
  output logic                  q_push,
  output qpst_evt_t             q_data
);

  logic               last_a_r, last_a_nxt;
  logic               last_b_r, last_b_nxt;
  logic [STAMP_W-1:0] last_stamp_r, last_stamp_nxt;
  logic               lvl_a, lvl_b;
  logic [STAMP_W-1:0] stamp;
  logic               chg_a, chg_b;
  qpst_dir_t          dir;

  assign lvl_a = in_tdata[0];
  assign lvl_b = in_tdata[1];
  assign stamp = in_tdata[STAMP_W+1:2];

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    chg_a = (lvl_a != last_a_r);
    chg_b = (lvl_b != last_b_r);
    if (chg_a == chg_b) begin
      dir = DIR_NONE;
    end else if (chg_a) begin
      dir = (lvl_a == lvl_b) ? DIR_ACW : DIR_CW;
    end else begin
      dir = (lvl_a == lvl_b) ? DIR_CW : DIR_ACW;
    end
    q_data.dir      = dir;
    q_data.interval = stamp - last_stamp_r;
    last_a_nxt      = q_push ? lvl_a : last_a_r;
    last_b_nxt      = q_push ? lvl_b : last_b_r;
    last_stamp_nxt  = q_push ? stamp : last_stamp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_a_r     <= 1'b0;
      last_b_r     <= 1'b0;
      last_stamp_r <= STAMP_RST;
    end else begin
      last_a_r     <= last_a_nxt;
      last_b_r     <= last_b_nxt;
      last_stamp_r <= last_stamp_nxt;
    end
  end

endmodule

### rtl/qpst_fifo.sv
// Short event queue between the input stage and the update engine.
module qpst_fifo
  import qpst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  qpst_evt_t   push_data,
  input  logic        pop,
  output qpst_evt_t   pop_data,
  output qpst_qstat_t stat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

  qpst_evt_t      mem_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [NCW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == NCW'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

### rtl/qpst_back.sv
// Update engine: position remainder and step, speed divide, history ring and average.
module qpst_back
  import qpst_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  qpst_cfg_t              cfg,
  input  qpst_qstat_t            q_stat,
  output logic                   q_pop,
  input  qpst_evt_t              q_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // position_count, step_direction, average_speed, pad
  output qpst_bstat_t            stat
);

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W = SPD_W + $clog2(HISTORY_DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(HISTORY_DEPTH - 1);
  localparam int RSH   = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int RCP_W = SUM_W + 1;
  localparam int PRD_W = SUM_W + RCP_W;
  localparam logic [63:0] RCP_WIDE = ((64'd1 << RSH) + 64'(HISTORY_DEPTH - 1))
                                     / 64'(HISTORY_DEPTH);
  localparam logic [RCP_W-1:0] RCP = RCP_WIDE[RCP_W-1:0];

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_AVG  = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  logic [PTR_W-1:0]          ptr_r, ptr_nxt;
  logic [PTR_W-1:0]          slot_r, slot_nxt;
  qpst_dir_t                 dir_r, dir_nxt;
  logic                      ivl_zero_r, ivl_zero_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [CNT_W-1:0]   pos_r, pos_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [HISTORY_DEPTH-1:0]  valid_r, valid_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [CNT_W-1:0]   out_pos_r, out_pos_nxt;
  qpst_dir_t                 out_dir_r, out_dir_nxt;
  logic [SPD_W-1:0]          out_avg_r, out_avg_nxt;

  logic                      mod_start, mod_busy;
  logic [MOD_W-1:0]          mod_rem, mod_dvs;
  logic [CNT_W-1:0]          pos_abs;
  logic                      spd_start, spd_busy;
  logic [SPD_W-1:0]          spd_dvd, spd_quo;
  logic [STAMP_W-1:0]        spd_dvs;
  logic                      ram_we;
  logic [SPD_W-1:0]          ram_rdata;
  logic [SPD_W-1:0]          speed;
  logic [SPD_W-1:0]          old_speed;
  logic [SUM_W-1:0]          sum_new;
  logic signed [CNT_W-1:0]   rem_s;
  logic signed [CNT_W-1:0]   pos_new;
  logic [PRD_W-1:0]          avg_prod;
  logic [SPD_W-1:0]          avg_q;
  logic                      load_out;

  qpst_div #(.NW(MOD_W), .DW(MOD_W)) u_mod_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (pos_abs[MOD_W-1:0]),
    .divisor  (mod_dvs),
    .busy     (mod_busy),
    .quo      (),
    .rem      (mod_rem)
  );

  qpst_div #(.NW(SPD_W), .DW(STAMP_W)) u_spd_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (spd_start),
    .dividend (spd_dvd),
    .divisor  (spd_dvs),
    .busy     (spd_busy),
    .quo      (spd_quo),
    .rem      ()
  );

  qpst_ram #(.WIDTH(SPD_W), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (speed),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    pos_abs   = pos_r[CNT_W-1] ? CNT_W'(-pos_r) : CNT_W'(pos_r);
    mod_dvs   = (cfg.count_modulus == '0) ? MOD_W'(1) : cfg.count_modulus;
    spd_dvd   = cfg.speed_numerator;
    spd_dvs   = q_data.interval;
    speed     = ivl_zero_r ? cfg.speed_numerator : spd_quo;
    old_speed = valid_r[slot_r] ? ram_rdata : '0;
    sum_new   = sum_r - SUM_W'(old_speed) + SUM_W'(speed);
    avg_prod  = PRD_W'(sum_r) * PRD_W'(RCP);
    avg_q     = avg_prod[RSH +: SPD_W];
    rem_s     = neg_r ? -$signed({1'b0, mod_rem}) : $signed({1'b0, mod_rem});
    case (dir_r)
      DIR_CW:  pos_new = rem_s + CNT_W'(1);
      DIR_ACW: pos_new = rem_s - CNT_W'(1);
      default: pos_new = rem_s;
    endcase

    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    slot_nxt     = slot_r;
    dir_nxt      = dir_r;
    ivl_zero_nxt = ivl_zero_r;
    neg_nxt      = neg_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    valid_nxt    = valid_r;
    q_pop        = 1'b0;
    mod_start    = 1'b0;
    spd_start    = 1'b0;
    ram_we       = 1'b0;
    load_out     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          q_pop        = 1'b1;
          mod_start    = 1'b1;
          spd_start    = 1'b1;
          dir_nxt      = q_data.dir;
          ivl_zero_nxt = (q_data.interval == '0);
          neg_nxt      = pos_r[CNT_W-1];
          slot_nxt     = (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (!mod_busy && !spd_busy) begin
          ram_we            = 1'b1;
          valid_nxt[slot_r] = 1'b1;
          ptr_nxt           = slot_r;
          sum_nxt           = sum_new;
          pos_nxt           = pos_new;
          state_nxt         = S_AVG;
        end
      end
      S_AVG: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r && !out_tready;
    out_pos_nxt   = out_pos_r;
    out_dir_nxt   = out_dir_r;
    out_avg_nxt   = out_avg_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = pos_r;
      out_dir_nxt   = dir_r;
      out_avg_nxt   = avg_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r     <= slot_nxt;
    dir_r      <= dir_nxt;
    ivl_zero_r <= ivl_zero_nxt;
    neg_r      <= neg_nxt;
    out_pos_r  <= out_pos_nxt;
    out_dir_r  <= out_dir_nxt;
    out_avg_r  <= out_avg_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - CNT_W - DIR_W - SPD_W)'(0),
                       out_avg_r, out_dir_r, out_pos_r};
  assign stat.idle  = (state_r == S_IDLE);
  assign stat.avg   = (state_r == S_AVG);

endmodule

### sim/tb_quadrature_position_speed_tracker_core.sv
// Self-checking testbench of the quadrature position and speed tracker core.
`timescale 1ns / 100ps

module tb_quadrature_position_speed_tracker_core;
  import qpst_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 80;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 75;

  typedef struct {
    logic signed [CNT_W-1:0] count;
    qpst_dir_t               dir;
    logic [SPD_W-1:0]        avg;
  } track_res_t;

  typedef struct {
    bit                 a;
    bit                 b;
    logic [STAMP_W-1:0] stamp;
    bit                 typed;
    track_res_t         res;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // level_a, level_b, stamp_us[31:0], zero pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // position_count, step_direction, average_speed, pad
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // tracker state mirrored by the testbench
  logic [MOD_W-1:0]   mod_reg = COUNT_MODULUS_RST;
  logic [SPD_W-1:0]   num_reg = SPEED_NUMERATOR_RST;
  bit                 prev_a = 1'b0;
  bit                 prev_b = 1'b0;
  int                 pos = 0;
  logic [STAMP_W-1:0] prev_stamp = STAMP_RST;
  int unsigned        slot_ptr = 0;
  logic [SPD_W-1:0]   speed_hist [HISTORY_DEPTH_DEF];
  int unsigned        hist_sum = 0;

  track_res_t pending_res [$];
  bit         failed = 1'b0;
  bit         calm = 1'b0;
  int         rdy_left = 0;
  int         cycles = 0;

  stim_row_t edge_tbl [14] = '{
    '{1'b0, 1'b0, 32'd1,          1'b1, '{17'sd0, DIR_NONE, 20'd735}},
    '{1'b1, 1'b0, 32'd2,          1'b1, '{17'sd1, DIR_CW,   20'd1470}},
    '{1'b1, 1'b1, 32'd2,          1'b1, '{17'sd2, DIR_CW,   20'd2205}},
    '{1'b0, 1'b1, 32'd12,         1'b1, '{17'sd3, DIR_CW,   20'd2279}},
    '{1'b0, 1'b0, 32'd112,        1'b0, '{17'sd0, DIR_NONE, 20'd0}},
    '{1'b0, 1'b1, 32'd113,        1'b0, '{17'sd0, DIR_NONE, 20'd0}},
    '{1'b1, 1'b1, 32'd150,        1'b0, '{17'sd0, DIR_NONE, 20'd0}},
    '{1'b1, 1'b1, 32'd151,        1'b0, '{17'sd0, DIR_NONE, 20'd0}},
    '{1'b0, 1'b0, 32'd160,        1'b0, '{17'sd0, DIR_NONE, 20'd0}},
    '{1'b1, 1'b0, 32'hFFFF_FFFF,  1'b0, '{17'sd0, DIR_NONE, 20'd0}},
    '{1'b0, 1'b1, 32'h0000_0004,  1'b0, '{17'sd0, DIR_NONE, 20'd0}},
    '{1'b0, 1'b0, 32'h0000_0004,  1'b0, '{17'sd0, DIR_NONE, 20'd0}},
    '{1'b0, 1'b1, 32'h8000_0000,  1'b0, '{17'sd0, DIR_NONE, 20'd0}},
    '{1'b1, 1'b1, 32'h7FFF_FFFF,  1'b0, '{17'sd0, DIR_NONE, 20'd0}}
  };

  quadrature_position_speed_tracker_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic track_res_t track_edge(bit a, bit b, logic [STAMP_W-1:0] stamp);
    track_res_t         r;
    bit                 ca;
    bit                 cb;
    int                 m;
    int unsigned        slot;
    logic [STAMP_W-1:0] span;
    logic [STAMP_W-1:0] speed;
    ca = (a != prev_a);
    cb = (b != prev_b);
    if (ca == cb) r.dir = DIR_NONE;
    else if (ca) r.dir = (a == b) ? DIR_ACW : DIR_CW;
    else r.dir = (a == b) ? DIR_CW : DIR_ACW;
    prev_a = a;
    prev_b = b;
    m = (mod_reg == '0) ? 1 : int'(mod_reg);
    pos = pos % m;
    if (r.dir == DIR_CW) pos = pos + 1;
    else if (r.dir == DIR_ACW) pos = pos - 1;
    slot = slot_ptr + 1;
    if (slot >= HISTORY_DEPTH_DEF) slot = 0;
    slot_ptr = slot;
    span = stamp - prev_stamp;
    speed = (span == '0) ? STAMP_W'(num_reg) : STAMP_W'(num_reg) / span;
    prev_stamp = stamp;
    hist_sum = hist_sum - speed_hist[slot] + speed;
    speed_hist[slot] = speed[SPD_W-1:0];
    r.count = pos[CNT_W-1:0];
    r.avg = SPD_W'(hist_sum / HISTORY_DEPTH_DEF);
    return r;
  endfunction

  task automatic send_edge(bit a, bit b, logic [STAMP_W-1:0] stamp, bit typed,
                           track_res_t typed_res);
    track_res_t r;
    int         gap;
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({stamp, b, a});
    do @(posedge clk); while (!in_tready);
    r = track_edge(a, b, stamp);
    pending_res.push_back(typed ? typed_res : r);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [MOD_W-1:0] modulus, logic [SPD_W-1:0] numerator);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_COUNT_MODULUS;
    cfg_wdata <= CFG_DATA_W'(modulus);
    @(posedge clk);
    cfg_addr <= CFG_SPEED_NUMERATOR;
    cfg_wdata <= numerator;
    @(posedge clk);
    cfg_we <= 1'b0;
    mod_reg = modulus;
    num_reg = numerator;
  endtask

  task automatic run_random(int n);
    bit                 lv_a [4] = '{1'b0, 1'b1, 1'b1, 1'b0};
    bit                 lv_b [4] = '{1'b0, 1'b0, 1'b1, 1'b1};
    int                 idx;
    int                 run_left;
    bit                 spin_cw;
    bit                 a;
    bit                 b;
    int                 r;
    logic [STAMP_W-1:0] stamp_now;
    track_res_t         unused;
    idx = 0;
    for (int k = 0; k < 4; k++)
      if (lv_a[k] == prev_a && lv_b[k] == prev_b) idx = k;
    run_left = 0;
    spin_cw = 1'b1;
    stamp_now = prev_stamp;
    unused = '{17'sd0, DIR_NONE, 20'd0};
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        spin_cw = $urandom_range(0, 1);
        run_left = $urandom_range(1, 40);
      end
      run_left--;
      if ($urandom_range(0, 99) < 85) begin
        idx = spin_cw ? (idx + 1) % 4 : (idx + 3) % 4;
        a = lv_a[idx];
        b = lv_b[idx];
      end else begin
        a = $urandom_range(0, 1);
        b = $urandom_range(0, 1);
        for (int k = 0; k < 4; k++)
          if (lv_a[k] == a && lv_b[k] == b) idx = k;
      end
      r = $urandom_range(0, 99);
      if (r < 70) stamp_now = stamp_now + $urandom_range(1, 300);
      else if (r < 80) stamp_now = stamp_now + $urandom_range(301, 100000);
      else if (r < 86) stamp_now = stamp_now;
      else if (r < 94) stamp_now = stamp_now + $urandom_range(1, 20);
      else stamp_now = $urandom;
      send_edge(a, b, stamp_now, 1'b0, unused);
    end
  endtask

  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (rdy_left != 0) begin
      rdy_left <= rdy_left - 1;
    end else begin
      out_tready <= ~out_tready;
      rdy_left <= out_tready ? pick_gap() : $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin : result_check
    track_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_res.size() == 0) begin
        $error("result transaction with none expected: %h", out_tdata);
        failed = 1'b1;
      end else begin
        want = pending_res.pop_front();
        if (out_tdata[16:0] !== want.count) begin
          $error("position_count: expected %0d, got %0d", want.count,
                 $signed(out_tdata[16:0]));
          failed = 1'b1;
        end
        if (out_tdata[18:17] !== want.dir) begin
          $error("step_direction: expected %0d, got %0d", want.dir, out_tdata[18:17]);
          failed = 1'b1;
        end
        if (out_tdata[38:19] !== want.avg) begin
          $error("average_speed: expected %0d, got %0d", want.avg, out_tdata[38:19]);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** quadrature_position_speed_tracker_core: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [MOD_W-1:0] mod_tbl [N_PHASES];
    logic [SPD_W-1:0] num_tbl [N_PHASES];
    foreach (speed_hist[k]) speed_hist[k] = '0;
    mod_tbl = '{16'd1, 16'd65535, 16'd0, 16'd2, 16'd7, 16'd65535, 16'd1200, 16'd0};
    num_tbl = '{20'd1048575, 20'd1, 20'd0, 20'd500, 20'd73526, 20'd1048575, 20'd0,
                20'd1048575};
    mod_tbl[6] = $urandom_range(1, 65535);
    num_tbl[6] = $urandom_range(1, 1048575);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (edge_tbl[i])
      send_edge(edge_tbl[i].a, edge_tbl[i].b, edge_tbl[i].stamp, edge_tbl[i].typed,
                edge_tbl[i].res);
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_and_settle();
      write_regs(mod_tbl[ph], num_tbl[ph]);
      calm = (ph == 3);
      run_random(ITEMS_PER_PHASE);
    end
    calm = 1'b0;
    drain_and_settle();
    if (!failed) begin
      $display("** quadrature_position_speed_tracker_core: PASSED **");
    end else begin
      $display("** quadrature_position_speed_tracker_core: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/qpst_pkg.sv
rtl/qpst_ram.sv
rtl/qpst_div.sv
rtl/qpst_front.sv
rtl/qpst_fifo.sv
rtl/qpst_back.sv
rtl/quadrature_position_speed_tracker_core.sv
sim/tb_quadrature_position_speed_tracker_core.sv
